>>> src/spq_pkg.sv
// Shared types and constants for the stable priority queue.
`default_nettype none
package spq_pkg;

   // number of record slots in the cell chain
   localparam int DEPTH = 16;

   // field widths
   localparam int CUST_W  = 37;
   localparam int ITEM_W  = 8;
   localparam int PRIO_W  = 4;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // request opcodes
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_op_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // one stored record
   typedef struct packed {
      logic [CUST_W-1:0] cust_id;
      logic [ITEM_W-1:0] item_count;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type ent;
   } cmd_type;

endpackage
`default_nettype wire

>>> src/spq_if.sv
// Request and response channel interfaces of the stable priority queue.
`default_nettype none
interface spq_req_if;
   import spq_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [CUST_W-1:0] cust_id;
   logic [ITEM_W-1:0] item_count;
   logic [PRIO_W-1:0] priority_req;

   modport source (output valid, req_type, cust_id, item_count, priority_req, input ready);
   modport sink   (input valid, req_type, cust_id, item_count, priority_req, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic              out_valid;
   logic [CUST_W-1:0] out_cust_id;
   logic [ITEM_W-1:0] out_item_count;
   logic [PRIO_W-1:0] out_priority;
   logic [OCC_W-1:0]  occupancy;
   logic              is_empty;

   modport source (output valid, status, out_valid, out_cust_id, out_item_count,
                   out_priority, occupancy, is_empty, input ready);
   modport sink   (input valid, status, out_valid, out_cust_id, out_item_count,
                   out_priority, occupancy, is_empty, output ready);
endinterface
`default_nettype wire

>>> src/spq_cell.sv
// One slot of the sorted cell chain: holds a record and shifts it left or right.
`default_nettype none
module spq_cell (
   input  wire                clock,
   input  spq_pkg::cmd_type   cmd,
   input  wire                occupied,
   input  spq_pkg::entry_type left_entry,
   input  wire                left_le,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic               le
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // flag a stored record that stays ahead of the new one
   assign le    = occupied && (entry_ff.prio <= cmd.ent.prio);
   assign entry = entry_ff;

   // pick the next record: hold, take the new one, shift right or shift left
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins && !le) begin
         entry_in = left_le ? cmd.ent : left_entry;
      end else if (cmd.rem) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

>>> src/stable_priority_queue_unit.sv
// Top level of the stable priority queue: cell chain, occupancy count, result register.
`default_nettype none
// Bounded priority queue of customer records kept sorted in a chain of DEPTH cells.
// On every request beat (insert or remove) all cells compare their priority with
// the incoming one in parallel and shift one place, so a new request is taken every
// cycle while no response beat waits, and its response beat appears in the output
// register on the next cycle. Outside reset, requests stall only while a response
// beat waits to be taken. Lower priority values come out first; equal priorities
// leave in arrival order. A remove on an empty queue reports empty and an insert
// into a full queue is dropped and flagged; neither changes the contents. No
// clearing pass is needed after reset: only slots below the record count are read.
module stable_priority_queue_unit (
   input wire  clock,
   input wire  reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);
   import spq_pkg::*;

   // request handshake
   logic accept;
   logic is_insert;
   logic is_remove;
   logic full;
   logic empty;
   cmd_type cmd;

   // count and result registers
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          status_ff;
   status_type          status_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   entry_type           out_entry_ff;
   entry_type           out_entry_in;
   logic [OCC_W-1:0]    occ_ff;
   logic [OCC_W-1:0]    occ_in;
   logic                is_empty_ff;
   logic [COUNT_W+OCC_W-1:0] occ_wide;

   // cell chain wiring
   entry_type  cell_entry [DEPTH];
   logic       cell_le    [DEPTH];
   logic       cell_occ   [DEPTH];

   assign req_if.ready = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign full         = (count_ff == COUNT_W'(DEPTH));
   assign empty        = (count_ff == '0);
   assign is_insert    = accept && (req_if.req_type == REQ_INSERT) && !full;
   assign is_remove    = accept && (req_if.req_type == REQ_REMOVE) && !empty;

   // broadcast the command to all cells
   always_comb begin
      cmd.ins            = is_insert;
      cmd.rem            = is_remove;
      cmd.ent.cust_id    = req_if.cust_id;
      cmd.ent.item_count = req_if.item_count;
      cmd.ent.prio       = req_if.priority_req;
   end

   // build the chain: each cell sees its neighbors; the head's left is the new record, the tail's right is itself
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_type left_e;
      logic      left_l;
      entry_type right_e;

      assign cell_occ[gi] = (count_ff > COUNT_W'(gi));

      if (gi == 0) begin : g_head
         assign left_e = cmd.ent;
         assign left_l = 1'b1;
      end else begin : g_body
         assign left_e = cell_entry[gi-1];
         assign left_l = cell_le[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
         assign right_e = cell_entry[gi];
      end else begin : g_mid
         assign right_e = cell_entry[gi+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (cell_occ[gi]),
         .left_entry  (left_e),
         .left_le     (left_l),
         .right_entry (right_e),
         .entry       (cell_entry[gi]),
         .le          (cell_le[gi])
      );
   end

   // next count
   always_comb begin
      count_in = count_ff;
      if (is_insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (is_remove) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   // form the response beat
   always_comb begin
      status_in = STATUS_OK;
      if (req_if.req_type == REQ_REMOVE && empty) begin
         status_in = STATUS_EMPTY;
      end else if (req_if.req_type == REQ_INSERT && full) begin
         status_in = STATUS_FULL;
      end
      out_valid_in = is_remove;
      out_entry_in = is_remove ? cell_entry[0] : '0;
      occ_wide     = {{OCC_W{1'b0}}, count_in};
      occ_in       = occ_wide[OCC_W-1:0];
   end

   // hold the response beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         out_valid_ff <= out_valid_in;
         out_entry_ff <= out_entry_in;
         occ_ff       <= occ_in;
         is_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.out_valid      = out_valid_ff;
   assign rsp_if.out_cust_id    = out_entry_ff.cust_id;
   assign rsp_if.out_item_count = out_entry_ff.item_count;
   assign rsp_if.out_priority   = out_entry_ff.prio;
   assign rsp_if.occupancy      = occ_ff;
   assign rsp_if.is_empty       = is_empty_ff;

   // count never passes the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("record count beyond depth");

   // a successful insert grows the count by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      is_insert |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("insert did not grow count");

   // a delivered record always carries ok status
   a_out_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_valid_ff) |-> status_ff == STATUS_OK)
      else $error("removed record with error status");

   // a remove of the last stored record empties the queue
   a_remove_empty: assert property (@(posedge clock) disable iff (reset)
      (is_remove && count_ff == COUNT_W'(1)) |=> is_empty_ff && empty)
      else $error("last remove did not empty the queue");

endmodule
`default_nettype wire
